@@ rtl/core/crcfr_pkg.sv @@
// Shared types, codes and the CRC byte step for the CRC-16 frame receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package crcfr_pkg;

    // Field widths of the stream words
    localparam int BYTE_W   = 8;
    localparam int EVENT_W  = 3;
    localparam int INDEX_W  = 10;
    localparam int FLEN_W   = 11;
    localparam int TOTAL_W  = 32;
    localparam int LEN_W    = 16;
    localparam int TMO_W    = 16;

    // Packed widths of the ports
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 128;
    localparam int M_TUSER_W = 3;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Hard ceiling on the payload length, applied on top of the configured max_len
    localparam logic [LEN_W-1:0] MAX_PAYLOAD = 16'd1024;
    localparam int COUNTER_WIDTH_DEF = 32;

    // CRC-16/CCITT-FALSE
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_SOF_FIRST = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SOF_SECOND = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_EOF_FIRST = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_EOF_SECOND = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAX_LEN = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CRC_LEN = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 3'd6;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EVENT_W-1:0] EV_BYTE    = 3'd1;
    localparam logic [EVENT_W-1:0] EV_GOOD    = 3'd2;
    localparam logic [EVENT_W-1:0] EV_CRC     = 3'd3;
    localparam logic [EVENT_W-1:0] EV_END     = 3'd4;
    localparam logic [EVENT_W-1:0] EV_SIZE    = 3'd5;
    localparam logic [EVENT_W-1:0] EV_SYNC    = 3'd6;
    localparam logic [EVENT_W-1:0] EV_TIMEOUT = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0]  sof_first;
        logic [BYTE_W-1:0]  sof_second;
        logic [BYTE_W-1:0]  eof_first;
        logic [BYTE_W-1:0]  eof_second;
        logic [FLEN_W-1:0]  max_len;
        logic               crc_len;
        logic [TMO_W-1:0]   timeout;
    } cfg_t;

    typedef struct packed {
        logic               func;
        logic [BYTE_W-1:0]  rx_byte;
    } item_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [BYTE_W-1:0]  data_byte;
        logic [INDEX_W-1:0] byte_index;
        logic [FLEN_W-1:0]  frame_length;
        logic [TOTAL_W-1:0] bytes_total;
        logic [TOTAL_W-1:0] frames_good_total;
        logic [TOTAL_W-1:0] errors_total;
    } result_t;

    // One byte through the MSB-first CRC, eight shallow XOR steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [BYTE_W-1:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if ((c & CRC_MSB) != 16'h0000)
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/crcfr_regs.sv @@
// APB register file for the frame receiver: markers, length limit, CRC mode, timeout.
// Depends on crcfr_pkg.
`default_nettype none

module crcfr_regs (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [crcfr_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire  [crcfr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [crcfr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    output crcfr_pkg::cfg_t                   cfg
);
    import crcfr_pkg::*;

    cfg_t cfg_reg;
    logic [REG_IDX_W-1:0] idx;
    logic wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    // Register writes on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sof_first  <= 8'hAA;
            cfg_reg.sof_second <= 8'h55;
            cfg_reg.eof_first  <= 8'h55;
            cfg_reg.eof_second <= 8'hAA;
            cfg_reg.max_len    <= 11'd1024;
            cfg_reg.crc_len    <= 1'b1;
            cfg_reg.timeout    <= 16'd100;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_SOF_FIRST:  cfg_reg.sof_first  <= pwdata[BYTE_W-1:0];
                REG_SOF_SECOND: cfg_reg.sof_second <= pwdata[BYTE_W-1:0];
                REG_EOF_FIRST:  cfg_reg.eof_first  <= pwdata[BYTE_W-1:0];
                REG_EOF_SECOND: cfg_reg.eof_second <= pwdata[BYTE_W-1:0];
                REG_MAX_LEN:    cfg_reg.max_len    <= pwdata[FLEN_W-1:0];
                REG_CRC_LEN:    cfg_reg.crc_len    <= pwdata[0];
                REG_TIMEOUT:    cfg_reg.timeout    <= pwdata[TMO_W-1:0];
                default:        ;
            endcase
        end
    end

    // Read-back mux
    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_SOF_FIRST:  prdata = APB_DATA_W'(cfg_reg.sof_first);
            REG_SOF_SECOND: prdata = APB_DATA_W'(cfg_reg.sof_second);
            REG_EOF_FIRST:  prdata = APB_DATA_W'(cfg_reg.eof_first);
            REG_EOF_SECOND: prdata = APB_DATA_W'(cfg_reg.eof_second);
            REG_MAX_LEN:    prdata = APB_DATA_W'(cfg_reg.max_len);
            REG_CRC_LEN:    prdata = APB_DATA_W'(cfg_reg.crc_len);
            REG_TIMEOUT:    prdata = APB_DATA_W'(cfg_reg.timeout);
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/crcfr_in_stage.sv @@
// Input register of the frame receiver: captures one word from the slave stream.
// Depends on crcfr_pkg.
`default_nettype none

module crcfr_in_stage (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [crcfr_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire  [crcfr_pkg::S_TUSER_W-1:0]  s_tuser,
    input  wire                              take,
    output logic                             item_valid,
    output crcfr_pkg::item_t                 item
);
    import crcfr_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // Free slot, or the held word leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.func    <= s_tuser[0];
            item_reg.rx_byte <= s_tdata[BYTE_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/crcfr_deframer.sv @@
// Deframing state machine, running CRC, counters and result register.
// Depends on crcfr_pkg.
`default_nettype none

module crcfr_deframer #(
    parameter int COUNTER_WIDTH = crcfr_pkg::COUNTER_WIDTH_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  crcfr_pkg::cfg_t      cfg,
    input  wire                  item_valid,
    input  crcfr_pkg::item_t     item,
    output logic                 take,
    output logic                 out_valid,
    input  wire                  out_ready,
    output crcfr_pkg::result_t   result
);
    import crcfr_pkg::*;

    localparam logic [3:0] PH_SOF0 = 4'd0;
    localparam logic [3:0] PH_SOF1 = 4'd1;
    localparam logic [3:0] PH_LEN0 = 4'd2;
    localparam logic [3:0] PH_LEN1 = 4'd3;
    localparam logic [3:0] PH_DATA = 4'd4;
    localparam logic [3:0] PH_CRC0 = 4'd5;
    localparam logic [3:0] PH_CRC1 = 4'd6;
    localparam logic [3:0] PH_EOF0 = 4'd7;
    localparam logic [3:0] PH_EOF1 = 4'd8;

    localparam int IDLE_W = TMO_W + 1;

    logic [3:0]               phase_reg, phase_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [FLEN_W-1:0]        pos_reg, pos_next;
    logic [15:0]              crc_reg, crc_next;
    logic [15:0]              rcrc_reg, rcrc_next;
    logic [IDLE_W-1:0]        idle_reg, idle_next;
    logic [COUNTER_WIDTH-1:0] byte_cnt_reg, byte_cnt_next;
    logic [COUNTER_WIDTH-1:0] good_cnt_reg, good_cnt_next;
    logic [COUNTER_WIDTH-1:0] err_cnt_reg, err_cnt_next;
    logic                     out_valid_reg;
    result_t                  result_reg, result_next;

    logic [FLEN_W-1:0]        pos_inc;
    logic [LEN_W-1:0]         len_full;
    logic [LEN_W-1:0]         limit;
    logic [15:0]              crc_upd;
    logic [BYTE_W-1:0]        b;

    assign take      = item_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    assign b        = item.rx_byte;
    assign crc_upd  = crc_byte(crc_reg, b);
    assign pos_inc  = pos_reg + FLEN_W'(1);
    assign len_full = {b, len_reg[7:0]};
    assign limit    = (LEN_W'(cfg.max_len) < MAX_PAYLOAD) ? LEN_W'(cfg.max_len) : MAX_PAYLOAD;

    // Next state and result for the word in the input register
    always_comb
    begin
        logic drop;
        logic err_inc;
        drop          = 1'b0;
        err_inc       = 1'b0;
        phase_next    = phase_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        rcrc_next     = rcrc_reg;
        idle_next     = idle_reg;
        byte_cnt_next = byte_cnt_reg;
        good_cnt_next = good_cnt_reg;
        result_next   = '0;
        result_next.event_res = EV_NONE;

        if (item.func)
        begin
            // time tick: saturate past any timeout value
            idle_next = idle_reg[IDLE_W-1] ? idle_reg : idle_reg + IDLE_W'(1);
            if (phase_reg != PH_SOF0 && idle_next > IDLE_W'(cfg.timeout))
            begin
                drop    = 1'b1;
                err_inc = 1'b1;
                result_next.event_res = EV_TIMEOUT;
            end
        end
        else
        begin
            byte_cnt_next = byte_cnt_reg + COUNTER_WIDTH'(1);
            idle_next     = '0;
            unique case (phase_reg)
                PH_SOF0:
                begin
                    if (b == cfg.sof_first)
                    begin
                        phase_next = PH_SOF1;
                    end
                end
                PH_SOF1:
                begin
                    if (b == cfg.sof_second)
                    begin
                        phase_next = PH_LEN0;
                        crc_next   = CRC_INIT;
                    end
                    else
                    begin
                        err_inc    = 1'b1;
                        result_next.event_res = EV_SYNC;
                        phase_next = (b == cfg.sof_first) ? PH_SOF1 : PH_SOF0;
                    end
                end
                PH_LEN0:
                begin
                    len_next = LEN_W'(b);
                    if (cfg.crc_len)
                    begin
                        crc_next = crc_upd;
                    end
                    phase_next = PH_LEN1;
                end
                PH_LEN1:
                begin
                    len_next = len_full;
                    if (cfg.crc_len)
                    begin
                        crc_next = crc_upd;
                    end
                    pos_next = '0;
                    if (len_full > limit)
                    begin
                        err_inc = 1'b1;
                        result_next.event_res = EV_SIZE;
                        drop    = 1'b1;
                    end
                    else
                    begin
                        phase_next = (len_full == '0) ? PH_CRC0 : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    crc_next = crc_upd;
                    result_next.event_res    = EV_BYTE;
                    result_next.data_byte    = b;
                    result_next.byte_index   = pos_reg[INDEX_W-1:0];
                    result_next.frame_length = len_reg[FLEN_W-1:0];
                    pos_next = pos_inc;
                    if (LEN_W'(pos_inc) >= len_reg)
                    begin
                        phase_next = PH_CRC0;
                    end
                end
                PH_CRC0:
                begin
                    rcrc_next  = 16'(b);
                    phase_next = PH_CRC1;
                end
                PH_CRC1:
                begin
                    rcrc_next  = {b, rcrc_reg[7:0]};
                    phase_next = PH_EOF0;
                end
                PH_EOF0:
                begin
                    if (b == cfg.eof_first)
                    begin
                        phase_next = PH_EOF1;
                    end
                    else
                    begin
                        err_inc = 1'b1;
                        result_next.event_res    = EV_END;
                        result_next.frame_length = len_reg[FLEN_W-1:0];
                        drop    = 1'b1;
                    end
                end
                PH_EOF1:
                begin
                    result_next.frame_length = len_reg[FLEN_W-1:0];
                    if (b != cfg.eof_second)
                    begin
                        err_inc = 1'b1;
                        result_next.event_res = EV_END;
                    end
                    else if (crc_reg == rcrc_reg)
                    begin
                        good_cnt_next = good_cnt_reg + COUNTER_WIDTH'(1);
                        result_next.event_res = EV_GOOD;
                    end
                    else
                    begin
                        err_inc = 1'b1;
                        result_next.event_res = EV_CRC;
                    end
                    drop = 1'b1;
                end
                default:
                begin
                    drop = 1'b1;
                end
            endcase
        end

        // end or abandon the frame, back to hunting for a start byte
        if (drop)
        begin
            phase_next = PH_SOF0;
            len_next   = '0;
            pos_next   = '0;
            crc_next   = CRC_INIT;
            rcrc_next  = '0;
        end

        // one running total stands for the sum of all error counters
        err_cnt_next = err_inc ? err_cnt_reg + COUNTER_WIDTH'(1) : err_cnt_reg;

        result_next.bytes_total       = TOTAL_W'(byte_cnt_next);
        result_next.frames_good_total = TOTAL_W'(good_cnt_next);
        result_next.errors_total      = TOTAL_W'(err_cnt_next);
    end

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SOF0;
            len_reg       <= '0;
            pos_reg       <= '0;
            crc_reg       <= CRC_INIT;
            rcrc_reg      <= '0;
            idle_reg      <= '0;
            byte_cnt_reg  <= '0;
            good_cnt_reg  <= '0;
            err_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg    <= phase_next;
                len_reg      <= len_next;
                pos_reg      <= pos_next;
                crc_reg      <= crc_next;
                rcrc_reg     <= rcrc_next;
                idle_reg     <= idle_next;
                byte_cnt_reg <= byte_cnt_next;
                good_cnt_reg <= good_cnt_next;
                err_cnt_reg  <= err_cnt_next;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/crc16_frame_receiver_core.sv @@
// CRC-16 frame receiver: usage overview.
// Slave stream: one word per received byte (tuser[0] = 0, tdata[7:0] = byte)
// or per time tick (tuser[0] = 1, tdata ignored).
// Master stream: exactly one result word per input word, in order: the event
// code in tuser, the forwarded payload byte, its index, the frame length and
// the byte, good-frame and error totals (values after that input word).
// Frames: two start bytes, 16-bit little-endian length, payload, 16-bit
// little-endian CRC-16/CCITT-FALSE, two end bytes; markers, length limit,
// CRC coverage and idle timeout are set over the APB port.
// Path: a word accepted from the slave stream is captured in the input
// register, and its result is then held in the result register.
// Throughput: one word per cycle unless the master stalls; the CRC byte
// step and the phase decode fit between the input and result registers.
// Reset: registers return to their defaults, counters clear, the deframer
// hunts for the first start byte. A master-side stall holds the result word;
// the input register still takes one more word, then s_tready drops.
// Depends on crcfr_pkg, crcfr_regs, crcfr_in_stage, crcfr_deframer.
`default_nettype none

module crc16_frame_receiver_core #(
    parameter int COUNTER_WIDTH = crcfr_pkg::COUNTER_WIDTH_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    // APB configuration port
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [crcfr_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire  [crcfr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [crcfr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    // slave stream
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [crcfr_pkg::S_TDATA_W-1:0]   s_tdata,  // [7:0] rx_byte
    input  wire  [crcfr_pkg::S_TUSER_W-1:0]   s_tuser,  // [0] func
    // master stream
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // [7:0] data_byte, [17:8] byte_index, [28:18] frame_length,
    // [60:29] bytes_total, [92:61] frames_good_total, [124:93] errors_total
    output logic [crcfr_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [crcfr_pkg::M_TUSER_W-1:0]   m_tuser   // [2:0] event_res
);
    import crcfr_pkg::*;

    cfg_t    cfg;
    item_t   item;
    result_t result;
    logic    item_valid;
    logic    take;

    crcfr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crcfr_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    crcfr_deframer #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_deframer (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .result     (result)
    );

    // Pack the result word
    assign m_tuser = result.event_res;
    assign m_tdata = {3'b000,
                      result.errors_total,
                      result.frames_good_total,
                      result.bytes_total,
                      result.frame_length,
                      result.byte_index,
                      result.data_byte};

    // A forwarded payload byte always lies inside its frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == EV_BYTE) |-> (11'(m_tdata[17:8]) < m_tdata[28:18]))
        else $error("payload byte index not below frame length");

    // Only payload events carry a data byte and an index
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != EV_BYTE) |-> (m_tdata[17:0] == 18'd0))
        else $error("data byte or index set on a non-payload event");

    // The input side only stalls behind a stalled full output register
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output can drain");

endmodule

`default_nettype wire
